[rtl/bpgf_pkg.sv]
package bpgf_pkg;

  localparam int PitchW = 16;
  localparam int RateW = 16;
  localparam int TimeW = 32;
  localparam int DriveW = 16;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [StatusW-1:0] STATUS_REGULATING = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NO_SAMPLE = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FAILSAFE = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_PITCH_REFERENCE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_ANGLE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_INTEGRAL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_RATE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_GRAVITY = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRATOR_LIMIT = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_FAILSAFE_ANGLE = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_LIMIT = 3'd7;

  localparam logic [14:0] FAILSAFE_RESET = 15'd6434;

  localparam int SIGN_LEFT = 1;
  localparam int SIGN_RIGHT = 1;

  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic [15:0] DT_DEFAULT_US = 16'd1000;
  localparam logic [31:0] DT_MAX_US = 32'd50000;
  localparam logic [17:0] DIV_DIVISOR = 18'd15625;
  localparam logic [25:0] DIV_RECIP = 26'd35184372;
  localparam logic [41:0] DIV_ROUND = 42'd7812;
  localparam logic [3:0] DIV_EST_STEP = 4'd0;
  localparam logic [3:0] DIV_REM_STEP = 4'd1;
  localparam logic signed [27:0] CORDIC_GAIN_Q24 = 28'sd10188014;

  localparam int CORDIC_STEPS = 16;
  localparam int MUL_TERMS = 4;
  localparam int CntW = 6;

  localparam logic [1:0] TERM_ANGLE = 2'd0;
  localparam logic [1:0] TERM_INTEGRAL = 2'd1;
  localparam logic [1:0] TERM_RATE = 2'd2;
  localparam logic [1:0] TERM_GRAVITY = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PRODUCT,
    S_LOAD,
    S_ITER,
    S_INTEG,
    S_MUL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       check;
    logic       product;
    logic       load;
    logic       iter;
    logic [3:0] step;
    logic       integ;
    logic       mul_issue;
    logic       acc_en;
    logic [1:0] term;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic regulating;
  } sts_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0: v = 20'sd51472;
      4'd1: v = 20'sd30385;
      4'd2: v = 20'sd16055;
      4'd3: v = 20'sd8150;
      4'd4: v = 20'sd4091;
      4'd5: v = 20'sd2047;
      4'd6: v = 20'sd1024;
      4'd7: v = 20'sd512;
      4'd8: v = 20'sd256;
      4'd9: v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

endpackage

[rtl/bpgf_if.sv]
interface bpgf_in_if import bpgf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     sample_valid;
  logic signed [PitchW-1:0] pitch_angle;
  logic signed [RateW-1:0]  pitch_rate;
  logic [TimeW-1:0]         time_us;

  modport source(output valid, sample_valid, pitch_angle, pitch_rate, time_us, input ready);
  modport sink(input valid, sample_valid, pitch_angle, pitch_rate, time_us, output ready);
endinterface

interface bpgf_out_if import bpgf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive_left;
  logic signed [DriveW-1:0] drive_right;
  logic [StatusW-1:0]       status;

  modport source(output valid, drive_left, drive_right, status, input ready);
  modport sink(input valid, drive_left, drive_right, status, output ready);
endinterface

[rtl/balance_pid_gravity_feedforward_unit.sv]
// Balance controller: PID on pitch with gravity feed-forward.
// Samples arrive on the in_ch channel and one result per sample leaves on
// out_ch; each transfer happens on a clock edge where valid and ready are high.
// Registers are written through cfg_we, cfg_index and cfg_data; write them
// only while idle, as the block itself does not enforce it. A regulating
// sample passes the check, product and load states, 16 CORDIC sine steps
// (the integrator step's divide by one million runs alongside as a reciprocal
// estimate followed by compare and subtract), the integrator state and the
// gain products on the shared multiplier, then the output register is loaded.
// An invalid or failsafe sample goes from the check straight to that load.
// A new sample is accepted in the cycle after the result is loaded, so the
// block does not take a new sample while one is being computed.
// The result is held in an output register; while the receiver stalls, the
// next sample can still be taken and computed, and it waits in the last step
// until the register is free. Synchronous reset clears the integrator, the
// stored timestamp and the handshake state and restores the register defaults.
module balance_pid_gravity_feedforward_unit import bpgf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bpgf_in_if.sink              in_ch,
  bpgf_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  bpgf_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts(sts),
    .cmd(cmd)
  );

  bpgf_datapath u_datapath (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_sample_valid(in_ch.sample_valid),
    .in_pitch_angle(in_ch.pitch_angle),
    .in_pitch_rate(in_ch.pitch_rate),
    .in_time_us(in_ch.time_us),
    .out_drive_left(out_ch.drive_left),
    .out_drive_right(out_ch.drive_right),
    .out_status(out_ch.status)
  );

endmodule

[rtl/bpgf_datapath.sv]
module bpgf_datapath import bpgf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgDataW-1:0]      cfg_data,
  input  logic                     in_sample_valid,
  input  logic signed [PitchW-1:0] in_pitch_angle,
  input  logic signed [RateW-1:0]  in_pitch_rate,
  input  logic [TimeW-1:0]         in_time_us,
  output logic signed [DriveW-1:0] out_drive_left,
  output logic signed [DriveW-1:0] out_drive_right,
  output logic [StatusW-1:0]       out_status
);

  logic signed [15:0] ref_r;
  logic [15:0] ga_r, gi_r, gr_r, gg_r, il_r;
  logic [14:0] fs_r, dl_r;

  logic sv_r;
  logic signed [15:0] pitch_r, rate_r;
  logic [31:0] time_r;
  logic signed [31:0] integ_r;
  logic [31:0] prev_r;
  logic [StatusW-1:0] code_r;
  logic signed [16:0] err_r;
  logic [15:0] delta_r;
  logic neg_r;
  logic [31:0] m_r;
  logic [41:0] n_r;
  logic [17:0] rem_r;
  logic [27:0] q_r;
  logic signed [27:0] x_r, y_r;
  logic signed [19:0] z_r;
  logic signed [15:0] sin_r;
  logic signed [48:0] prod_r;
  logic [1:0] term_r;
  logic signed [53:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
      ga_r <= '0;
      gi_r <= '0;
      gr_r <= '0;
      gg_r <= '0;
      il_r <= '0;
      fs_r <= FAILSAFE_RESET;
      dl_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PITCH_REFERENCE:  ref_r <= cfg_data;
        CFG_GAIN_ANGLE:       ga_r <= cfg_data;
        CFG_GAIN_INTEGRAL:    gi_r <= cfg_data;
        CFG_GAIN_RATE:        gr_r <= cfg_data;
        CFG_GAIN_GRAVITY:     gg_r <= cfg_data;
        CFG_INTEGRATOR_LIMIT: il_r <= cfg_data;
        CFG_FAILSAFE_ANGLE:   fs_r <= cfg_data[14:0];
        CFG_DRIVE_LIMIT:      dl_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic signed [16:0] pitch_x, mag;
  logic [31:0] delta_raw;
  logic delta_bad;
  assign pitch_x = 17'(pitch_r);
  assign mag = pitch_r[15] ? -pitch_x : pitch_x;
  assign sts.regulating = sv_r && (mag <= $signed({2'b00, fs_r}));
  assign delta_raw = time_r - prev_r;
  assign delta_bad = (prev_r == '0) || (delta_raw == '0) || (delta_raw > DT_MAX_US);

  logic signed [33:0] ed;
  assign ed = err_r * $signed({1'b0, delta_r});

  logic signed [16:0] fold;
  always_comb begin
    if (pitch_x > HALF_PI_Q13) fold = PI_Q13 - pitch_x;
    else if (pitch_x < -HALF_PI_Q13) fold = -PI_Q13 - pitch_x;
    else fold = pitch_x;
  end

  // The rounded divide by one million reduces to a divide by 15625; a reciprocal
  // estimate is at most nine low and is finished by compare and subtract.
  logic [57:0] dprod;
  logic [41:0] qm, dres;
  assign dprod = n_r[41:10] * DIV_RECIP;
  assign qm = q_r * DIV_DIVISOR;
  assign dres = n_r - qm;

  logic signed [27:0] xs, ys;
  logic signed [19:0] at;
  assign xs = x_r >>> cmd.step;
  assign ys = y_r >>> cmd.step;
  assign at = atan_q16(cmd.step);

  logic signed [28:0] inc;
  logic signed [33:0] isum, ilim;
  logic signed [27:0] yr;
  logic signed [17:0] sraw;
  assign inc = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign isum = 34'(integ_r) + 34'(inc);
  assign ilim = $signed({3'b000, il_r, 15'd0});
  assign yr = (y_r + 28'sd512) >>> 10;
  assign sraw = yr[17:0];

  logic signed [16:0] ma;
  logic signed [31:0] mb;
  always_comb begin
    case (cmd.term)
      TERM_ANGLE:    begin ma = $signed({1'b0, ga_r}); mb = 32'(err_r); end
      TERM_INTEGRAL: begin ma = $signed({1'b0, gi_r}); mb = integ_r; end
      TERM_RATE:     begin ma = $signed({1'b0, gr_r}); mb = 32'(rate_r); end
      default:       begin ma = $signed({1'b0, gg_r}); mb = 32'(sin_r); end
    endcase
  end

  logic signed [53:0] pe, addend;
  assign pe = 54'(prod_r);
  always_comb begin
    case (term_r)
      TERM_ANGLE:    addend = pe <<< 15;
      TERM_INTEGRAL: addend = pe;
      TERM_RATE:     addend = -(pe <<< 18);
      default:       addend = -(pe <<< 14);
    endcase
  end

  logic signed [53:0] rnd;
  logic signed [28:0] u29, dlx;
  logic signed [15:0] u;
  assign rnd = acc_r + 54'sd16777216;
  assign u29 = rnd[53:25];
  assign dlx = $signed({14'd0, dl_r});
  always_comb begin
    if (u29 > dlx) u = 16'(dlx);
    else if (u29 < -dlx) u = 16'(-dlx);
    else u = u29[15:0];
  end

  function automatic logic signed [15:0] apply_sign(input int s, input logic signed [15:0] v);
    logic signed [15:0] r;
    if (s > 0) r = v;
    else if (s < 0) r = -v;
    else r = '0;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r <= '0;
    end else begin
      if (cmd.check && sv_r) begin
        if (!sts.regulating) begin
          integ_r <= '0;
        end else begin
          prev_r <= time_r;
        end
      end
      if (cmd.integ) begin
        if (isum > ilim) integ_r <= ilim[31:0];
        else if (isum < -ilim) integ_r <= 32'(-ilim);
        else integ_r <= isum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sv_r <= in_sample_valid;
      pitch_r <= in_pitch_angle;
      rate_r <= in_pitch_rate;
      time_r <= in_time_us;
    end
    if (cmd.check) begin
      code_r <= !sv_r ? STATUS_NO_SAMPLE : (sts.regulating ? STATUS_REGULATING : STATUS_FAILSAFE);
      err_r <= 17'(ref_r) - pitch_x;
      delta_r <= delta_bad ? DT_DEFAULT_US : delta_raw[15:0];
    end
    if (cmd.product) begin
      neg_r <= ed[33];
      m_r <= ed[33] ? 32'(-ed) : ed[31:0];
    end
    if (cmd.load) begin
      n_r <= {1'b0, m_r, 9'd0} + DIV_ROUND;
      x_r <= CORDIC_GAIN_Q24;
      y_r <= '0;
      z_r <= 20'(fold) <<< 3;
    end
    if (cmd.iter) begin
      if (cmd.step == DIV_EST_STEP) begin
        q_r <= dprod[56:29];
      end else if (cmd.step == DIV_REM_STEP) begin
        rem_r <= dres[17:0];
      end else if (rem_r >= DIV_DIVISOR) begin
        rem_r <= rem_r - DIV_DIVISOR;
        q_r <= q_r + 28'd1;
      end
      if (!z_r[19]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.integ) begin
      if (sraw > 18'sd16384) sin_r <= 16'sd16384;
      else if (sraw < -18'sd16384) sin_r <= -16'sd16384;
      else sin_r <= sraw[15:0];
      acc_r <= '0;
    end
    if (cmd.mul_issue) begin
      prod_r <= ma * mb;
      term_r <= cmd.term;
    end
    if (cmd.acc_en) begin
      acc_r <= acc_r + addend;
    end
    if (cmd.load_out) begin
      out_status <= code_r;
      if (code_r == STATUS_REGULATING) begin
        out_drive_left <= apply_sign(SIGN_LEFT, u);
        out_drive_right <= apply_sign(SIGN_RIGHT, u);
      end else begin
        out_drive_left <= '0;
        out_drive_right <= '0;
      end
    end
  end

endmodule

[rtl/bpgf_ctrl.sv]
module bpgf_ctrl import bpgf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = '0;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = sts.regulating ? S_PRODUCT : S_FINISH;
      S_PRODUCT: state_nxt = S_LOAD;
      S_LOAD:    state_nxt = S_ITER;
      S_ITER: begin
        if (cnt_r == CntW'(CORDIC_STEPS - 1)) state_nxt = S_INTEG;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_INTEG:   state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == CntW'(MUL_TERMS)) state_nxt = S_FINISH;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_FINISH:  if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.step = cnt_r[3:0];
    cmd.term = cnt_r[1:0];
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE:    cmd.capture = in_valid;
      S_CHECK:   cmd.check = 1'b1;
      S_PRODUCT: cmd.product = 1'b1;
      S_LOAD:    cmd.load = 1'b1;
      S_ITER:    cmd.iter = 1'b1;
      S_INTEG:   cmd.integ = 1'b1;
      S_MUL: begin
        cmd.mul_issue = cnt_r < CntW'(MUL_TERMS);
        cmd.acc_en = cnt_r != '0;
      end
      S_FINISH: begin
        cmd.load_out = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result dropped while stalled");
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not presented");
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CHECK)
    else $error("accepted sample not checked");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ITER |-> cnt_r < CntW'(CORDIC_STEPS))
    else $error("iteration count overrun");

endmodule

[tb/sv/balance_pid_gravity_feedforward_unit_tb.sv]
`timescale 1ns / 1ps

module balance_pid_gravity_feedforward_unit_tb;
  import bpgf_pkg::*;

  typedef struct packed {
    logic             sample_valid;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] pitch_rate;
    logic [31:0]      time_us;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic [1:0]         status;
  } drive_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  bpgf_in_if in_ch();
  bpgf_out_if out_ch();

  balance_pid_gravity_feedforward_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Controller copy kept by the testbench.
  logic signed [15:0] m_reference;
  logic [15:0] m_kp, m_ki, m_kd, m_kg, m_ilim;
  logic [14:0] m_failsafe, m_dlim;
  logic signed [31:0] m_integ;
  logic [31:0] m_prev_time;

  sample_t pending_samples[$];
  drive_t expected_drives[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit idling_on = 1'b1;
  int hold_off = 0;
  bit timed_out = 1'b0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sine_q14(longint a);
    longint x, y, z, t, xs, ys;
    longint atan_tab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    x = 10188014;
    y = 0;
    if (a > 12868) a = 25736 - a;
    else if (a < -12868) a = -25736 - a;
    z = a * 8;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        t = x - ys; y = y + xs; z -= atan_tab[i];
      end else begin
        t = x + ys; y = y - xs; z += atan_tab[i];
      end
      x = t;
    end
    t = floor_shift(y + 512, 10);
    if (t > 16384) t = 16384;
    if (t < -16384) t = -16384;
    return t;
  endfunction

  function automatic void controller_reset();
    m_reference = 0; m_kp = 0; m_ki = 0; m_kd = 0; m_kg = 0; m_ilim = 0;
    m_failsafe = FAILSAFE_RESET; m_dlim = 0; m_integ = 0; m_prev_time = 0;
  endfunction

  function automatic drive_t compute_drive(sample_t s);
    drive_t d;
    longint pitch, rate, mag, err, prod, inc, acc, lim, u;
    logic [31:0] delta;
    d.drive_left = 0;
    d.drive_right = 0;
    if (!s.sample_valid) begin
      d.status = STATUS_NO_SAMPLE;
      return d;
    end
    pitch = s.pitch_angle;
    rate = s.pitch_rate;
    mag = pitch < 0 ? -pitch : pitch;
    if (mag > longint'(m_failsafe)) begin
      m_integ = 0;
      d.status = STATUS_FAILSAFE;
      return d;
    end
    err = longint'(m_reference) - pitch;
    delta = s.time_us - m_prev_time;
    if (m_prev_time == 0 || delta == 0 || delta > DT_MAX_US) delta = 1000;
    m_prev_time = s.time_us;
    prod = err * longint'(delta) * 32768;
    mag = prod < 0 ? -prod : prod;
    inc = (mag + 500000) / 1000000;
    if (prod < 0) inc = -inc;
    acc = longint'(m_integ) + inc;
    lim = longint'(m_ilim) * 32768;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    m_integ = 32'(acc);
    acc = longint'(m_kp) * err * 32768 + longint'(m_ki) * longint'(m_integ)
        - longint'(m_kd) * rate * 262144
        - longint'(m_kg) * sine_q14(pitch) * 16384;
    u = floor_shift(acc + (longint'(1) << 24), 25);
    if (u > longint'(m_dlim)) u = m_dlim;
    if (u < -longint'(m_dlim)) u = -longint'(m_dlim);
    d.drive_left = 16'(SIGN_LEFT * u);
    d.drive_right = 16'(SIGN_RIGHT * u);
    d.status = STATUS_REGULATING;
    return d;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    errors++;
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PITCH_REFERENCE: m_reference = val;
      CFG_GAIN_ANGLE: m_kp = val;
      CFG_GAIN_INTEGRAL: m_ki = val;
      CFG_GAIN_RATE: m_kd = val;
      CFG_GAIN_GRAVITY: m_kg = val;
      CFG_INTEGRATOR_LIMIT: m_ilim = val;
      CFG_FAILSAFE_ANGLE: m_failsafe = val[14:0];
      default: m_dlim = val[14:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_drives.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Driver.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) n_sent++;
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          expected_drives.push_back(compute_drive(s));
          in_ch.valid <= 1'b1;
          in_ch.sample_valid <= s.sample_valid;
          in_ch.pitch_angle <= s.pitch_angle;
          in_ch.pitch_rate <= s.pitch_rate;
          in_ch.time_us <= s.time_us;
          if (idling_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        drive_t want;
        if (expected_drives.size() == 0) begin
          $display("unexpected result transfer");
          errors++;
        end else begin
          want = expected_drives.pop_front();
          if (out_ch.drive_left !== want.drive_left)
            report_mismatch("drive_left", out_ch.drive_left, want.drive_left);
          if (out_ch.drive_right !== want.drive_right)
            report_mismatch("drive_right", out_ch.drive_right, want.drive_right);
          if (out_ch.status !== want.status)
            report_mismatch("status", out_ch.status, want.status);
        end
        n_checked++;
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 16);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off > 0)
      idle_cycles <= 0;
    else if (in_ch.valid || expected_drives.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("balance_pid_gravity_feedforward_unit_tb: done, errors");
      $finish;
    end
  end

  logic [31:0] clock_us = 32'd100;

  function automatic sample_t random_sample(int fs);
    sample_t s;
    s.sample_valid = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 5))
      0: s.pitch_angle = 16'($urandom);
      1: s.pitch_angle = 16'($signed(fs) + $signed($urandom_range(0, 4)) - 2);
      2: s.pitch_angle = -16'(fs);
      default: s.pitch_angle = 16'($signed($urandom_range(0, 2 * fs)) - fs);
    endcase
    s.pitch_rate = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                   16'($signed($urandom_range(0, 4000)) - 2000);
    case ($urandom_range(0, 9))
      0: clock_us = $urandom;
      1: clock_us = clock_us + $urandom_range(50001, 200000);
      2: clock_us = 0;
      3: clock_us = clock_us;
      default: clock_us = clock_us + $urandom_range(500, 2000);
    endcase
    s.time_us = clock_us;
    return s;
  endfunction

  initial begin
    sample_t s;
    int fs;
    in_ch.valid = 1'b0;
    in_ch.sample_valid = 1'b0;
    in_ch.pitch_angle = '0;
    in_ch.pitch_rate = '0;
    in_ch.time_us = '0;
    out_ch.ready = 1'b0;
    controller_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: drive limit is zero so every regulating result is zero.
    s = '{1'b1, 16'sd100, 16'sd0, 32'd1000};
    pending_samples.push_back(s);
    wait_drained();

    write_register(CFG_PITCH_REFERENCE, 16'h8000);
    write_register(CFG_GAIN_ANGLE, 16'hFFFF);
    write_register(CFG_GAIN_INTEGRAL, 16'hFFFF);
    write_register(CFG_GAIN_RATE, 16'hFFFF);
    write_register(CFG_GAIN_GRAVITY, 16'hFFFF);
    write_register(CFG_INTEGRATOR_LIMIT, 16'hFFFF);
    write_register(CFG_FAILSAFE_ANGLE, 16'h7FFF);
    write_register(CFG_DRIVE_LIMIT, 16'h7FFF);
    pending_samples.push_back('{1'b0, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF});
    pending_samples.push_back('{1'b1, 16'sh7FFF, 16'sh7FFF, 32'd0});
    pending_samples.push_back('{1'b1, 16'sh8000, 16'sh8000, 32'd5});
    pending_samples.push_back('{1'b1, 16'sh8000, 16'sh8000, 32'd5});
    pending_samples.push_back('{1'b1, 16'sd12868, 16'sd0, 32'd60000});
    pending_samples.push_back('{1'b1, -16'sd12869, 16'sd0, 32'd60000});
    pending_samples.push_back('{1'b1, 16'sd25736, 16'sd1, 32'd110000});
    pending_samples.push_back('{1'b1, 16'sd0, -16'sd1, 32'hFFFF_FFFF});
    pending_samples.push_back('{1'b1, 16'sd1, 16'sd0, 32'd49999});
    wait_drained();
    write_register(CFG_FAILSAFE_ANGLE, 16'd6434);
    write_register(CFG_DRIVE_LIMIT, 16'd0);
    pending_samples.push_back('{1'b1, 16'sd6434, 16'sd5, 32'd1});
    pending_samples.push_back('{1'b1, 16'sd6435, 16'sd5, 32'd2});
    pending_samples.push_back('{1'b1, -16'sd6435, 16'sd5, 32'd3});
    wait_drained();
    write_register(CFG_DRIVE_LIMIT, 16'd4000);
    write_register(CFG_INTEGRATOR_LIMIT, 16'd0);

    // Long receiver stall while the sender keeps offering items.
    for (int i = 0; i < 8; i++) pending_samples.push_back(random_sample(6434));
    hold_off = 400;
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      write_register(CFG_PITCH_REFERENCE, $urandom_range(0, 1) ? pick16() : 16'($urandom_range(0, 800)));
      write_register(CFG_GAIN_ANGLE, pick16());
      write_register(CFG_GAIN_INTEGRAL, pick16());
      write_register(CFG_GAIN_RATE, pick16());
      write_register(CFG_GAIN_GRAVITY, pick16());
      write_register(CFG_INTEGRATOR_LIMIT, pick16());
      fs = (phase == 0) ? 32767 : $urandom_range(0, 32767);
      write_register(CFG_FAILSAFE_ANGLE, 16'(fs));
      write_register(CFG_DRIVE_LIMIT, phase == 1 ? 16'd0 : 16'($urandom_range(0, 32767)));
      if (phase == 5) idling_on = 1'b0;
      for (int i = 0; i < 190; i++) pending_samples.push_back(random_sample(fs));
      wait_drained();
    end

    $display("covered %0d samples sent and %0d results checked over six register settings",
             n_sent, n_checked);
    if (errors == 0) $display("balance_pid_gravity_feedforward_unit_tb: done, clean");
    else $display("balance_pid_gravity_feedforward_unit_tb: done, errors");
    $finish;
  end

endmodule

[sim.f]
rtl/bpgf_pkg.sv
rtl/bpgf_if.sv
rtl/bpgf_datapath.sv
rtl/bpgf_ctrl.sv
rtl/balance_pid_gravity_feedforward_unit.sv
tb/sv/balance_pid_gravity_feedforward_unit_tb.sv
